// ===== design/mwo_pkg.sv =====
// Shared types, constants and the sine lookup function of the multi-waveform oscillator.
package mwo_pkg;

    localparam int LEVEL_W    = 16;
    localparam int BASE_W     = 25;
    localparam int DEPTH_W    = 17;
    localparam int WAVE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int FREQ_W     = 27;   // signed working frequency, Q.8 Hz
    localparam int FPOS_W     = 26;   // positive working frequency
    localparam int PROD_W     = 34;   // level times depth
    localparam int SCALED_W   = 39;   // product times 20 plus rounding
    localparam int TERM_W     = 16;   // modulation offset, Q.8 Hz
    localparam int PHASE_QW   = 17;   // quotient bits of the phase division
    localparam int DEG_W      = 9;
    localparam int QIDX_W     = 7;
    localparam int LFSR_W     = 32;

    localparam logic [BASE_W-1:0]  BASE_FREQ_RESET = 25'd5120;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL      = 17'd65536;
    localparam logic [LFSR_W-1:0]  LFSR_RESET      = 32'd1;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS       = 32'h8020_0003;
    localparam logic [LEVEL_W-1:0] LEVEL_POS       = 16'h7FFF;
    localparam logic [LEVEL_W-1:0] LEVEL_NEG       = 16'h8000;
    localparam logic [DEG_W-1:0]   DEGREES         = 9'd360;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_ENABLE = 2'd3;

    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_PULSE8   = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_PULSE4   = 3'd5;
    localparam logic [WAVE_W-1:0] WAVE_NOISE    = 3'd6;

    localparam logic [LEVEL_W-1:0] QUARTER_SINE [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32767
    };

    typedef enum logic {
        DIV_PERIOD,
        DIV_PHASE
    } mwo_div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FREQ,
        ST_CHECK,
        ST_DIV_PERIOD,
        ST_COUNT,
        ST_LOAD_PHASE,
        ST_DIV_PHASE,
        ST_DEGREE,
        ST_LEVEL,
        ST_PUBLISH
    } mwo_state_t;

    typedef struct packed {
        logic         take_in;
        logic         mul;
        logic         freq;
        logic         check;
        logic         div_load;
        mwo_div_sel_t div_sel;
        logic         degree;
        logic         count;
        logic         level;
        logic         publish;
    } mwo_cmd_t;

    typedef struct packed {
        logic freq_pos;
        logic div_done;
        logic needs_div;
        logic is_sine;
        logic out_free;
    } mwo_stat_t;

    // Full-wave sine from the quarter table by symmetry; the negative peak is full scale.
    function automatic logic [LEVEL_W-1:0] sine_at(input logic [DEG_W-1:0] deg_in);
        logic [DEG_W-1:0]   deg;
        logic [DEG_W-1:0]   idx;
        logic [LEVEL_W-1:0] q;
        deg = (deg_in > 9'd359) ? 9'd359 : deg_in;
        if (deg <= 9'd90)
            idx = deg;
        else if (deg <= 9'd180)
            idx = 9'd180 - deg;
        else if (deg <= 9'd270)
            idx = deg - 9'd180;
        else
            idx = 9'd360 - deg;
        q = QUARTER_SINE[idx[QIDX_W-1:0]];
        if (deg <= 9'd180)
            return q;
        else if (q == LEVEL_POS)
            return LEVEL_NEG;
        else
            return 16'(16'd0 - q);
    endfunction

endpackage

// ===== design/mwo_mod_if.sv =====
// Modulator sample channel.
interface mwo_mod_if;
    import mwo_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] mod_level;

    modport source (output valid, output mod_level, input ready);
    modport sink (input valid, input mod_level, output ready);
endinterface

// ===== design/mwo_wave_if.sv =====
// Oscillator sample channel.
interface mwo_wave_if;
    import mwo_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] wave_level;
    logic                      held;

    modport source (output valid, output wave_level, output held, input ready);
    modport sink (input valid, input wave_level, input held, output ready);
endinterface

// ===== design/mwo_cfg_if.sv =====
// Configuration write channel.
interface mwo_cfg_if;
    import mwo_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mwo_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mwo_div #(
    parameter int QB = 27,
    parameter int DW = 27
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [DW-1:0]            rem_init,
    input  logic [QB-1:0]            dividend,
    input  logic [DW-1:0]            divisor,
    input  logic [$clog2(QB+1)-1:0]  steps,
    output logic [QB-1:0]            quotient,
    output logic                     done
);
    localparam int SW = $clog2(QB + 1);

    logic [SW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QB-1:0] q_reg, q_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial    = {rem_reg, q_reg[QB-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        dvs_next = dvs_reg;
        if (load)
        begin
            cnt_next = steps;
            rem_next = rem_init;
            q_next   = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - SW'(1);
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = {q_reg[QB-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = q_reg;
    assign done     = (cnt_reg == '0);

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load) |=> done)
        else $error("divider left done without a load");
endmodule

// ===== design/mwo_ctrl.sv =====
// Sequencer of the oscillator: walks one sample through the datapath.
module mwo_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mwo_pkg::mwo_stat_t stat,
    output mwo_pkg::mwo_cmd_t  cmd
);
    import mwo_pkg::*;

    mwo_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_PERIOD;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FREQ;
            end
            ST_FREQ:
            begin
                cmd.freq   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.freq_pos)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DIV_PERIOD;
                    state_next   = ST_DIV_PERIOD;
                end
                else
                    state_next = ST_PUBLISH;
            end
            ST_DIV_PERIOD:
            begin
                if (stat.div_done)
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = stat.needs_div ? ST_LOAD_PHASE : ST_LEVEL;
            end
            ST_LOAD_PHASE:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_PHASE;
                state_next   = ST_DIV_PHASE;
            end
            ST_DIV_PHASE:
            begin
                if (stat.div_done)
                    state_next = stat.is_sine ? ST_DEGREE : ST_LEVEL;
            end
            ST_DEGREE:
            begin
                cmd.degree = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_publish_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> stat.out_free)
        else $error("result published into a full output register");

    a_degree_sine: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEGREE) |-> stat.is_sine)
        else $error("degree scaling run for a wave other than sine");
endmodule

// ===== design/mwo_dp.sv =====
// Datapath of the oscillator: configuration, modulation, period, counter, wave shaping.
module mwo_dp #(
    parameter int RATE_HZ      = 48000,
    parameter int TABLE_POINTS = 360,
    parameter int COUNT_BITS   = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mwo_pkg::mwo_cmd_t                  cmd,
    output mwo_pkg::mwo_stat_t                 stat,
    input  logic                               cfg_write,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [mwo_pkg::LEVEL_W-1:0] mod_level,
    output logic                               wave_valid,
    input  logic                               wave_ready,
    output logic signed [mwo_pkg::LEVEL_W-1:0] wave_level,
    output logic                               held
);
    import mwo_pkg::*;

    localparam int NUM1_W = $clog2(RATE_HZ * 512 + 2 ** FPOS_W);
    localparam int DW     = (COUNT_BITS > FREQ_W) ? COUNT_BITS : FREQ_W;
    localparam int N2_W   = COUNT_BITS + PHASE_QW;
    localparam int CMP_W  = (NUM1_W > COUNT_BITS) ? NUM1_W : COUNT_BITS;
    localparam int SW     = $clog2(NUM1_W + 1);
    localparam logic [NUM1_W-1:0] RATE_SCALED = NUM1_W'(RATE_HZ * 512);

    // degree = idx * 360 / TABLE_POINTS by reciprocal multiply; exact for idx below
    // TABLE_POINTS up to 1024 points with a 29-bit shift
    localparam int     DEG_SHIFT  = 29;
    localparam int     DEG_MULT_W = 32;
    localparam int     DEG_PROD_W = PHASE_QW + DEG_MULT_W;
    localparam longint DEG_RECIP  = ((longint'(1) <<< DEG_SHIFT) + TABLE_POINTS - 1)
                                    / TABLE_POINTS;
    localparam logic [DEG_MULT_W-1:0] DEG_MULT = DEG_MULT_W'(longint'(DEGREES) * DEG_RECIP);

    // configuration
    logic [BASE_W-1:0]  base_freq_reg;
    logic [WAVE_W-1:0]  wave_sel_reg;
    logic [DEPTH_W-1:0] mod_depth_reg;
    logic               mod_enable_reg;

    // per-sample working registers
    logic signed [LEVEL_W-1:0] lvl_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [FREQ_W-1:0]  freq_reg;
    logic                      held_reg;
    logic [COUNT_BITS-1:0]     period_reg;
    logic [DEG_W-1:0]          degree_reg;
    logic [COUNT_BITS-1:0]     phase_count_reg;
    logic [LEVEL_W-1:0]        level_reg;
    logic [LFSR_W-1:0]         noise_lfsr_reg;

    // output register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_held_reg;

    logic [DEPTH_W-1:0]          depth_sat;
    logic signed [SCALED_W-1:0]  scaled;
    logic signed [TERM_W-1:0]    term;
    logic signed [FREQ_W-1:0]    freq_next;
    logic                        freq_pos;
    logic [FPOS_W-1:0]           fpos;
    logic [NUM1_W-1:0]           num1;
    logic [CMP_W-1:0]            q1_ext;
    logic [COUNT_BITS-1:0]       period_next;
    logic [COUNT_BITS-1:0]       count_inc;
    logic [COUNT_BITS-1:0]       count_next;
    logic                        first_half;
    logic [COUNT_BITS:0]         twice_minus;
    logic [N2_W-1:0]             num2;
    logic [DW-1:0]               div_rem_init;
    logic [NUM1_W-1:0]           div_dividend;
    logic [DW-1:0]               div_divisor;
    logic [SW-1:0]               div_steps;
    logic [NUM1_W-1:0]           div_quotient;
    logic                        div_done;
    logic [PHASE_QW-1:0]         quo;
    logic [DEG_PROD_W-1:0]       deg_prod;
    logic [DEG_W-1:0]            degree_next;
    logic [PHASE_QW-1:0]         tri_fall;
    logic [LFSR_W-1:0]           lfsr_step;
    logic [LEVEL_W-1:0]          level_next;
    logic [LFSR_W-1:0]           lfsr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_freq_reg  <= BASE_FREQ_RESET;
            wave_sel_reg   <= WAVE_SINE;
            mod_depth_reg  <= '0;
            mod_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE_FREQ:  base_freq_reg  <= cfg_data[BASE_W-1:0];
                CFG_WAVE_SEL:   wave_sel_reg   <= cfg_data[WAVE_W-1:0];
                CFG_MOD_DEPTH:  mod_depth_reg  <= cfg_data[DEPTH_W-1:0];
                CFG_MOD_ENABLE: mod_enable_reg <= cfg_data[0];
                default:        mod_enable_reg <= mod_enable_reg;
            endcase
        end
    end

    // modulation offset: round(level * depth * 20 / 2^23), floor of the half-up sum
    always_comb
    begin
        depth_sat = (mod_depth_reg > DEPTH_FULL) ? DEPTH_FULL : mod_depth_reg;
        scaled    = (SCALED_W'(prod_reg) <<< 4) + (SCALED_W'(prod_reg) <<< 2)
                    + SCALED_W'(1 << 22);
        term      = scaled[SCALED_W-1:23];
        freq_next = FREQ_W'($signed({1'b0, base_freq_reg}));
        if (mod_enable_reg)
            freq_next = freq_next + FREQ_W'(term);
        freq_pos  = !freq_reg[FREQ_W-1] && (freq_reg != '0);
        fpos      = freq_reg[FPOS_W-1:0];
        num1      = RATE_SCALED + NUM1_W'(fpos);
    end

    // period clamp and counter advance
    always_comb
    begin
        q1_ext = CMP_W'(div_quotient);
        if (q1_ext == '0)
            period_next = COUNT_BITS'(1);
        else if (q1_ext > CMP_W'({COUNT_BITS{1'b1}}))
            period_next = {COUNT_BITS{1'b1}};
        else
            period_next = q1_ext[COUNT_BITS-1:0];
        count_inc  = phase_count_reg + COUNT_BITS'(1);
        count_next = (count_inc >= period_next) ? '0 : count_inc;
    end

    // divider operand selection
    always_comb
    begin
        first_half  = {phase_count_reg, 1'b0} < {1'b0, period_reg};
        twice_minus = {phase_count_reg, 1'b0} - {1'b0, period_reg};
        quo         = div_quotient[PHASE_QW-1:0];
        if (wave_sel_reg == WAVE_SINE)
            num2 = N2_W'(phase_count_reg) * N2_W'(TABLE_POINTS);
        else if (wave_sel_reg == WAVE_SAW)
            num2 = N2_W'({phase_count_reg, 16'd0});
        else if (first_half)
            num2 = {phase_count_reg, 17'd0};
        else
            num2 = N2_W'({twice_minus[COUNT_BITS-1:0], 16'd0});
        unique case (cmd.div_sel)
            DIV_PERIOD:
            begin
                div_rem_init = '0;
                div_dividend = num1;
                div_divisor  = DW'({fpos, 1'b0});
                div_steps    = SW'(NUM1_W);
            end
            DIV_PHASE:
            begin
                div_rem_init = DW'(num2[N2_W-1:PHASE_QW]);
                div_dividend = {num2[PHASE_QW-1:0], (NUM1_W - PHASE_QW)'(0)};
                div_divisor  = DW'(period_reg);
                div_steps    = SW'(PHASE_QW);
            end
        endcase
    end

    // table index to degree
    always_comb
    begin
        deg_prod    = DEG_PROD_W'(quo) * DEG_PROD_W'(DEG_MULT);
        degree_next = deg_prod[DEG_SHIFT +: DEG_W];
    end

    mwo_div #(
        .QB (NUM1_W),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // wave shaping
    always_comb
    begin
        lfsr_step  = {1'b0, noise_lfsr_reg[LFSR_W-1:1]}
                     ^ (noise_lfsr_reg[0] ? LFSR_TAPS : '0);
        tri_fall   = PHASE_QW'(17'd32768) - quo;
        lfsr_next  = noise_lfsr_reg;
        level_next = level_reg;
        unique case (wave_sel_reg)
            WAVE_SINE:     level_next = sine_at(degree_reg);
            WAVE_SQUARE:   level_next = first_half ? LEVEL_POS : LEVEL_NEG;
            WAVE_SAW:      level_next = quo[LEVEL_W-1:0] ^ LEVEL_NEG;
            WAVE_TRIANGLE:
            begin
                if (first_half)
                    level_next = quo[LEVEL_W-1:0] ^ LEVEL_NEG;
                else if (quo == '0)
                    level_next = LEVEL_POS;
                else
                    level_next = tri_fall[LEVEL_W-1:0];
            end
            WAVE_PULSE8:
                level_next = ({phase_count_reg, 3'd0} < {3'd0, period_reg})
                             ? LEVEL_POS : LEVEL_NEG;
            WAVE_PULSE4:
                level_next = ({phase_count_reg, 2'd0} < {2'd0, period_reg})
                             ? LEVEL_POS : LEVEL_NEG;
            WAVE_NOISE:
            begin
                lfsr_next  = lfsr_step;
                level_next = lfsr_step[LFSR_W-1:LFSR_W-LEVEL_W];
            end
            default:       level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
            lvl_reg <= mod_level;
        if (cmd.mul)
            prod_reg <= lvl_reg * $signed({1'b0, depth_sat});
        if (cmd.freq)
            freq_reg <= freq_next;
        if (cmd.count)
            period_reg <= period_next;
        if (cmd.degree)
            degree_reg <= degree_next;
        if (cmd.publish)
        begin
            out_level_reg <= level_reg;
            out_held_reg  <= held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            phase_count_reg <= '0;
            level_reg       <= '0;
            noise_lfsr_reg  <= LFSR_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.check)
                held_reg <= !freq_pos;
            if (cmd.count)
                phase_count_reg <= count_next;
            if (cmd.level)
            begin
                level_reg      <= level_next;
                noise_lfsr_reg <= lfsr_next;
            end
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (wave_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.freq_pos  = freq_pos;
    assign stat.div_done  = div_done;
    assign stat.needs_div = (wave_sel_reg == WAVE_SINE) || (wave_sel_reg == WAVE_SAW)
                            || (wave_sel_reg == WAVE_TRIANGLE);
    assign stat.is_sine   = (wave_sel_reg == WAVE_SINE);
    assign stat.out_free  = !out_valid_reg || wave_ready;

    assign wave_valid = out_valid_reg;
    assign wave_level = out_level_reg;
    assign held       = out_held_reg;

    a_count_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count |=> (phase_count_reg < period_reg))
        else $error("sample counter not below the period after advance");

    a_hold_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && !freq_pos) |=> held_reg)
        else $error("nonpositive frequency not flagged as held");
endmodule

// ===== design/multi_waveform_oscillator_unit.sv =====
// Top level of the multi-waveform audio oscillator.
//
//  channel   | dir | payload                   | word
//  ----------+-----+---------------------------+------------------------------
//  mod_in    | in  | mod_level (s16 Q1.15)     | one modulator sample per tick
//  wave_out  | out | wave_level (s16), held    | one oscillator sample
//  cfg       | in  | index (2b), data (25b)    | one register write
//
// Work per word: the shared restoring divider, one quotient bit a cycle, finds
// the period (27 quotient bits at the default rate) for every word with a
// positive frequency, and the phase (17 bits) for saw, triangle and sine; sine
// then scales the table index to degrees by a constant multiply. A held word
// skips the divider.
// Reset: rst_n clears the sequencer, counter, last level, held flag and output
// valid, seeds the noise register and loads register defaults; no clearing pass.
// Stalls: a finished word waits in the output register; the next input word
// is taken while it waits, and the sequencer only stops when a second result
// is ready before the first has been taken. cfg is always ready.
module multi_waveform_oscillator_unit #(
    parameter int RATE_HZ      = 48000,
    parameter int TABLE_POINTS = 360,
    parameter int COUNT_BITS   = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    mwo_mod_if.sink         mod_in,
    mwo_wave_if.source      wave_out,
    mwo_cfg_if.sink         cfg
);
    import mwo_pkg::*;

    mwo_cmd_t  cmd;
    mwo_stat_t stat;
    logic      in_ready;

    // Registers are plain flops; take every write at once.
    assign cfg.ready    = 1'b1;
    assign mod_in.ready = in_ready;

    // Sequence one sample at a time: multiply, add, divide, advance, shape.
    mwo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mod_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold configuration, state and the output register.
    mwo_dp #(
        .RATE_HZ      (RATE_HZ),
        .TABLE_POINTS (TABLE_POINTS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_write  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .mod_level  (mod_in.mod_level),
        .wave_valid (wave_out.valid),
        .wave_ready (wave_out.ready),
        .wave_level (wave_out.wave_level),
        .held       (wave_out.held)
    );
endmodule
